// ===== rtl/core/majority_vote_bit_deframer_core_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef MAJORITY_VOTE_BIT_DEFRAMER_CORE_MACROS_SVH
`define MAJORITY_VOTE_BIT_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MVBD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Condition that must hold at every edge outside reset.
`define MVBD_ASSERT_ALWAYS(lbl, cond) \
    `MVBD_ASSERT_IMPL(lbl, 1'b1, cond)

`endif

// ===== rtl/core/mvbd_pkg.sv =====
// Constants and widths for the majority-vote bit deframer.
`default_nettype none

package mvbd_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int MAX_MSG_BITS   = 1024;
    localparam int PREAMBLE_FLIPS = 4;
    localparam int IGNORE_LIMIT   = 1000;

    localparam int LAT_W      = 16;
    localparam int THR_W      = 10;
    localparam int FLIPS_W    = $clog2(PREAMBLE_FLIPS + 1);
    localparam int MSG_BITS_W = $clog2(MAX_MSG_BITS + 1);

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [FLIPS_W-1:0]     t_flips;
    typedef logic [MSG_BITS_W-1:0]  t_msg_bits;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_END    = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/mvbd_if.sv =====
// Valid/ready channel interfaces for deframer input and result beats.
`default_nettype none

interface mvbd_in_if;
    import mvbd_pkg::*;
    logic             valid;
    logic             ready;
    logic             action;
    logic [LAT_W-1:0] latency;

    modport source (output valid, output action, output latency, input ready);
    modport sink   (input valid, input action, input latency, output ready);
endinterface

interface mvbd_out_if;
    logic       valid;
    logic       ready;
    logic       detected_bit;
    logic       in_message;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       message_end;
    logic       sync_found;

    modport source (output valid, output detected_bit, output in_message,
                    output byte_valid, output data_byte, output message_end,
                    output sync_found, input ready);
    modport sink   (input valid, input detected_bit, input in_message,
                    input byte_valid, input data_byte, input message_end,
                    input sync_found, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/majority_vote_bit_deframer_core.sv =====
// Majority-vote bit deframer: sample counting, preamble hunt and byte packing.
//
//  channel    dir  beat                                   handshake
//  i_item     in   action, latency                        valid/ready
//  o_result   out  bit, in_message, byte, end, sync       valid/ready
//  i_cfg_*    in   miss limit write                       write enable only
//
// One beat accepted per cycle unless a held result stalls the input register.
// A result is registered from its interval-end beat via the input register,
// then the result register. Sample beats make no result; they wait only behind
// a stalled interval end. Synchronous active-low reset resets counters, hunt
// state and valids; threshold returns to 150. A held result stalls an
// interval-end beat in the input register, and the input behind it.
`default_nettype none

module majority_vote_bit_deframer_core
    import mvbd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    mvbd_in_if.sink               i_item,
    mvbd_out_if.source            o_result
);

    logic [THR_W-1:0] r_threshold;

    // input register
    logic             r_s1_valid;
    logic             r_s1_action;
    logic [LAT_W-1:0] r_s1_latency;

    // deframer state
    t_count    r_miss_count,   n_miss_count;
    t_count    r_sample_count, n_sample_count;
    logic      r_prev_bit,     n_prev_bit;
    t_flips    r_flips_left,   n_flips_left;
    logic      r_message_mode, n_message_mode;
    logic [7:0] r_byte_shift,  n_byte_shift;
    logic [2:0] r_bit_in_byte, n_bit_in_byte;
    t_msg_bits r_message_bits, n_message_bits;

    // result register
    logic       r_out_valid;
    logic       r_out_bit,   n_out_bit;
    logic       r_out_msg,   n_out_msg;
    logic       r_out_bval,  n_out_bval;
    logic [7:0] r_out_byte,  n_out_byte;
    logic       r_out_end,   n_out_end;
    logic       r_out_sync,  n_out_sync;

    logic out_free;
    logic s1_go;
    logic bit_det;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_go        = r_s1_valid && ((r_s1_action == ACT_SAMPLE) || out_free);
    assign i_item.ready = !r_s1_valid || s1_go;

    // twice misses above count, no overflow in the doubled term
    assign bit_det = {r_miss_count, 1'b0} > {1'b0, r_sample_count};

    always_comb begin
        n_miss_count   = r_miss_count;
        n_sample_count = r_sample_count;
        n_prev_bit     = r_prev_bit;
        n_flips_left   = r_flips_left;
        n_message_mode = r_message_mode;
        n_byte_shift   = r_byte_shift;
        n_bit_in_byte  = r_bit_in_byte;
        n_message_bits = r_message_bits;
        n_out_bit      = bit_det;
        n_out_msg      = 1'b0;
        n_out_bval     = 1'b0;
        n_out_byte     = 8'd0;
        n_out_end      = 1'b0;
        n_out_sync     = 1'b0;

        if (r_s1_action == ACT_SAMPLE) begin
            if (r_s1_latency < LAT_W'(IGNORE_LIMIT)) begin
                if (r_sample_count != '1) begin
                    n_sample_count = r_sample_count + 1'b1;
                end
                if (r_s1_latency > LAT_W'(r_threshold) && r_miss_count != '1) begin
                    n_miss_count = r_miss_count + 1'b1;
                end
            end
        end else begin
            n_miss_count   = '0;
            n_sample_count = '0;
            if (r_message_mode) begin
                n_out_msg      = 1'b1;
                n_byte_shift   = {r_byte_shift[6:0], bit_det};
                n_bit_in_byte  = r_bit_in_byte + 3'd1;
                n_message_bits = MSG_BITS_W'(r_message_bits + 1'b1);
                if (n_bit_in_byte == 3'd0) begin
                    if (n_byte_shift != 8'd0) begin
                        n_out_bval = 1'b1;
                        n_out_byte = n_byte_shift;
                    end else begin
                        n_out_end = 1'b1;
                    end
                    n_byte_shift = 8'd0;
                end
                if (n_message_bits >= MSG_BITS_W'(MAX_MSG_BITS)) begin
                    n_out_end = 1'b1;
                end
                if (n_out_end) begin
                    n_flips_left   = FLIPS_W'(PREAMBLE_FLIPS);
                    n_message_mode = 1'b0;
                    n_byte_shift   = 8'd0;
                    n_bit_in_byte  = 3'd0;
                    n_message_bits = '0;
                end
            end else begin
                if (r_flips_left == '0 && bit_det && r_prev_bit) begin
                    n_out_sync     = 1'b1;
                    n_message_mode = 1'b1;
                    n_byte_shift   = 8'd0;
                    n_bit_in_byte  = 3'd0;
                    n_message_bits = '0;
                end else if (r_flips_left != '0 && bit_det != r_prev_bit) begin
                    n_flips_left = r_flips_left - 1'b1;
                end else if (bit_det == r_prev_bit) begin
                    n_flips_left = FLIPS_W'(PREAMBLE_FLIPS);
                end
                n_prev_bit = bit_det;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THR_W'(150);
            r_s1_valid     <= 1'b0;
            r_miss_count   <= '0;
            r_sample_count <= '0;
            r_prev_bit     <= 1'b1;
            r_flips_left   <= FLIPS_W'(PREAMBLE_FLIPS);
            r_message_mode <= 1'b0;
            r_byte_shift   <= 8'd0;
            r_bit_in_byte  <= 3'd0;
            r_message_bits <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (s1_go) begin
                r_miss_count   <= n_miss_count;
                r_sample_count <= n_sample_count;
                r_prev_bit     <= n_prev_bit;
                r_flips_left   <= n_flips_left;
                r_message_mode <= n_message_mode;
                r_byte_shift   <= n_byte_shift;
                r_bit_in_byte  <= n_bit_in_byte;
                r_message_bits <= n_message_bits;
            end
            if (s1_go && r_s1_action == ACT_END) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_action  <= i_item.action;
            r_s1_latency <= i_item.latency;
        end
        if (s1_go && r_s1_action == ACT_END) begin
            r_out_bit  <= n_out_bit;
            r_out_msg  <= n_out_msg;
            r_out_bval <= n_out_bval;
            r_out_byte <= n_out_byte;
            r_out_end  <= n_out_end;
            r_out_sync <= n_out_sync;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.detected_bit = r_out_bit;
    assign o_result.in_message   = r_out_msg;
    assign o_result.byte_valid   = r_out_bval;
    assign o_result.data_byte    = r_out_byte;
    assign o_result.message_end  = r_out_end;
    assign o_result.sync_found   = r_out_sync;

`include "majority_vote_bit_deframer_core_macros.svh"

    `MVBD_ASSERT_IMPL(a_byte_in_msg, r_out_valid && r_out_bval, r_out_msg && !r_out_sync)
    `MVBD_ASSERT_IMPL(a_sync_hunt, r_out_valid && r_out_sync, r_out_bit && !r_out_msg && !r_out_end)
    `MVBD_ASSERT_IMPL(a_hunt_clear, !r_message_mode, r_bit_in_byte == 3'd0 && r_message_bits == '0)
    `MVBD_ASSERT_ALWAYS(a_flips_range, r_flips_left <= FLIPS_W'(PREAMBLE_FLIPS))

endmodule

`default_nettype wire

// ===== sim/tb_majority_vote_bit_deframer_core.sv =====
// Testbench for the majority-vote bit deframer core: directed and random beats checked against a predictor.
module tb_majority_vote_bit_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mvbd_pkg::*;

    localparam logic [THR_W-1:0] THR_RESET = 10'd150;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD  = 300;
    localparam int RANDOM_ITEMS   = 250;

    typedef struct packed {
        logic       det_bit;
        logic       in_message;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       message_end;
        logic       sync_found;
    } t_bit_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    mvbd_in_if  item_if ();
    mvbd_out_if result_if ();

    majority_vote_bit_deframer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [THR_W-1:0] thr_now      = THR_RESET;
    t_count           miss_tally   = '0;
    t_count           sample_tally = '0;
    logic             hunt_prev    = 1'b1;
    t_flips           hunt_flips   = t_flips'(PREAMBLE_FLIPS);
    logic             in_body      = 1'b0;
    logic [7:0]       byte_acc     = '0;
    logic [2:0]       byte_pos     = '0;
    t_msg_bits        body_len     = '0;

    t_bit_report reports_due[$];
    int fail_count   = 0;
    int useful_beats = 0;
    int quiet_cycles = 0;
    int stall_req    = 0;
    bit src_calm     = 1'b0;
    bit sink_calm    = 1'b0;

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic decode_beat(input logic act, input logic [LAT_W-1:0] lat);
        t_bit_report rep;
        logic b;
        if (act == ACT_SAMPLE) begin
            if (lat < IGNORE_LIMIT) begin
                if (sample_tally != '1) sample_tally++;
                if (lat > thr_now && miss_tally != '1) miss_tally++;
            end
            return;
        end
        rep = '0;
        // doubled miss count needs one extra bit
        b = ({1'b0, miss_tally, 1'b0} > {2'b00, sample_tally});
        miss_tally   = '0;
        sample_tally = '0;
        rep.det_bit  = b;
        if (in_body) begin
            rep.in_message = 1'b1;
            byte_acc = {byte_acc[6:0], b};
            byte_pos++;
            body_len++;
            if (byte_pos == 3'd0) begin
                if (byte_acc != 8'h00) begin
                    rep.byte_valid = 1'b1;
                    rep.data_byte  = byte_acc;
                end else begin
                    rep.message_end = 1'b1;
                end
                byte_acc = '0;
            end
            if (body_len >= MAX_MSG_BITS) rep.message_end = 1'b1;
            if (rep.message_end) begin
                hunt_flips = t_flips'(PREAMBLE_FLIPS);
                in_body    = 1'b0;
                byte_acc   = '0;
                byte_pos   = '0;
                body_len   = '0;
            end
        end else begin
            if (hunt_flips == 0 && b && hunt_prev) begin
                rep.sync_found = 1'b1;
                in_body  = 1'b1;
                byte_acc = '0;
                byte_pos = '0;
                body_len = '0;
            end else if (hunt_flips != 0 && b != hunt_prev) begin
                hunt_flips--;
            end else if (b == hunt_prev) begin
                hunt_flips = t_flips'(PREAMBLE_FLIPS);
            end
            hunt_prev = b;
        end
        reports_due.push_back(rep);
    endtask

    task automatic send_beat(input logic act, input logic [LAT_W-1:0] lat);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.action  <= act;
        item_if.latency <= lat;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        decode_beat(act, lat);
        if (act == ACT_END || lat < IGNORE_LIMIT) useful_beats++;
    endtask

    // one interval whose sample mix votes for b, or for zero when the threshold leaves no miss latency
    task automatic send_interval(input logic b);
        int n;
        int misses;
        if (b) begin
            n = $urandom_range(1, 5);
            misses = $urandom_range(n / 2 + 1, n);
        end else begin
            n = $urandom_range(0, 5);
            misses = $urandom_range(0, n / 2);
        end
        if (thr_now >= IGNORE_LIMIT - 1) misses = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_beat(ACT_SAMPLE, LAT_W'($urandom_range(IGNORE_LIMIT, 16'hFFFF)));
            if ($urandom_range(1, n - i) <= misses) begin
                send_beat(ACT_SAMPLE, LAT_W'($urandom_range(thr_now + 1, IGNORE_LIMIT - 1)));
                misses--;
            end else begin
                send_beat(ACT_SAMPLE, LAT_W'($urandom_range(0, thr_now)));
            end
        end
        send_beat(ACT_END, LAT_W'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic send_pattern(input logic [15:0] pat, input int len);
        for (int i = len - 1; i >= 0; i--) send_interval(pat[i]);
    endtask

    // 0,0 re-arms from any hunt state, then four flips and two ones
    task automatic send_preamble();
        while (in_body) send_interval(1'b0);
        send_pattern(16'b0010_1011, 8);
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [THR_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        thr_now = value;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // hunt from reset, a short message, zero terminator, re-arm and a second sync
    task automatic test_hunt_and_message();
        send_pattern(16'b0_1011, 5);
        send_pattern(16'h41, 8);
        send_pattern(16'h00, 8);
        // equal bit re-arms, four flips, a zero with no flips left keeps the flip count at zero
        send_pattern(16'b1010_1011, 8);
        send_pattern(16'hFF, 8);
        send_pattern(16'h00, 8);
    endtask

    task automatic test_sample_classification();
        send_beat(ACT_SAMPLE, LAT_W'(150));
        send_beat(ACT_SAMPLE, LAT_W'(151));
        send_beat(ACT_END, '1);
        send_beat(ACT_SAMPLE, LAT_W'(151));
        send_beat(ACT_END, '0);
        send_beat(ACT_END, LAT_W'(16'hA5A5));
        send_beat(ACT_SAMPLE, LAT_W'(IGNORE_LIMIT - 1));
        send_beat(ACT_SAMPLE, LAT_W'(IGNORE_LIMIT));
        send_beat(ACT_SAMPLE, '1);
        send_beat(ACT_END, LAT_W'(16'h5A5A));
        send_beat(ACT_SAMPLE, LAT_W'(IGNORE_LIMIT));
        send_beat(ACT_END, '0);
        send_beat(ACT_SAMPLE, '0);
        send_beat(ACT_SAMPLE, LAT_W'(151));
        send_beat(ACT_SAMPLE, LAT_W'(152));
        send_beat(ACT_END, '0);
    endtask

    task automatic test_threshold_extremes();
        cfg_write('0);
        send_beat(ACT_SAMPLE, '0);
        send_beat(ACT_END, '0);
        send_beat(ACT_SAMPLE, LAT_W'(1));
        send_beat(ACT_END, '0);
        cfg_write(THR_W'(IGNORE_LIMIT - 1));
        send_beat(ACT_SAMPLE, LAT_W'(IGNORE_LIMIT - 1));
        send_beat(ACT_SAMPLE, LAT_W'(IGNORE_LIMIT - 2));
        send_beat(ACT_END, '0);
    endtask

    // sink holds off while beats keep coming, so interval ends back up
    task automatic test_output_backpressure();
        cfg_write(THR_W'(280));
        stall_req = PRESSURE_HOLD;
        src_calm  = 1'b1;
        repeat (40) send_interval(1'($urandom_range(0, 1)));
        src_calm  = 1'b0;
    endtask

    task automatic test_random_traffic();
        int start;
        int kind;
        int n;
        logic [7:0] val;
        start = useful_beats;
        while (useful_beats - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                src_calm  = ($urandom_range(0, 2) == 0);
                sink_calm = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                send_preamble();
                n = $urandom_range(1, 4);
                repeat (n) begin
                    val = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                    send_pattern({8'h00, val}, 8);
                end
                if ($urandom_range(0, 4) != 0) send_pattern(16'h00, 8);
            end else if (kind < 17) begin
                n = $urandom_range(1, 10);
                repeat (n)
                    send_beat(1'($urandom_range(0, 1)), LAT_W'($urandom_range(0, 16'hFFFF)));
            end else if (kind < 19) begin
                n = $urandom_range(2, 8);
                repeat (n) send_interval(1'($urandom_range(0, 1)));
            end else begin
                cfg_write(THR_W'($urandom_range(1, IGNORE_LIMIT - 2)));
            end
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial begin : result_sink
        int low;
        forever begin
            low = pick_gap(sink_calm) + stall_req;
            stall_req = 0;
            if (low > 0) begin
                result_if.ready <= 1'b0;
                repeat (low) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_bit_report want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
                $display("%0t mismatch result beat: expected none, actual bit %0b byte %0h",
                         $time, result_if.detected_bit, result_if.data_byte);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("detected_bit", want.det_bit, result_if.detected_bit);
                check_field("in_message", want.in_message, result_if.in_message);
                check_field("byte_valid", want.byte_valid, result_if.byte_valid);
                check_field("data_byte", want.data_byte, result_if.data_byte);
                check_field("message_end", want.message_end, result_if.message_end);
                check_field("sync_found", want.sync_found, result_if.sync_found);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[majority_vote_bit_deframer_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        item_if.valid   <= 1'b0;
        item_if.action  <= ACT_SAMPLE;
        item_if.latency <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hunt_and_message();
        test_sample_classification();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && reports_due.size() == 0)
            $display("[majority_vote_bit_deframer_core] OK");
        else
            $display("[majority_vote_bit_deframer_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mvbd_pkg.sv
rtl/core/mvbd_if.sv
rtl/core/majority_vote_bit_deframer_core.sv
sim/tb_majority_vote_bit_deframer_core.sv
